// ----- rtl/dtc_pkg.sv -----
package dtc_pkg;

    localparam int TIME_W   = 63;
    localparam int WIDE_W   = 64;
    localparam int FACTOR_W = 21;
    localparam int PROD_W   = 85;
    localparam int ACC_W    = 88;
    localparam int REM_W    = 21;
    localparam int CNT_W    = 7;
    localparam int INDEX_W  = 2;

    localparam int MUL_STEPS = FACTOR_W;
    localparam int DIV_STEPS = PROD_W;

    localparam logic [FACTOR_W-1:0] SCALE_UNIT = FACTOR_W'(1000);

    localparam logic [INDEX_W-1:0] REG_FACTOR = 2'd0;
    localparam logic [INDEX_W-1:0] REG_START  = 2'd1;
    localparam logic [INDEX_W-1:0] REG_FREEZE = 2'd2;

    typedef struct packed {
        logic load;
        logic delta;
        logic absval;
        logic mul_step;
        logic div_step;
        logic sign;
        logic add_ev;
        logic add_start;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic bypass;
    } status_t;

endpackage

// ----- rtl/dtc_ctrl.sv -----
module dtc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    input  dtc_pkg::status_t status,
    output dtc_pkg::cmd_t    cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DELTA  = 4'd1;
    localparam logic [3:0] S_ABS    = 4'd2;
    localparam logic [3:0] S_MUL    = 4'd3;
    localparam logic [3:0] S_DIV    = 4'd4;
    localparam logic [3:0] S_SIGN   = 4'd5;
    localparam logic [3:0] S_ADDV   = 4'd6;
    localparam logic [3:0] S_ADDS   = 4'd7;
    localparam logic [3:0] S_FINISH = 4'd8;

    logic [3:0]                state_reg, state_next;
    logic [dtc_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      out_valid_reg, out_valid_next;
    logic                      accept;
    logic                      out_free;

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign accept    = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd.load   = 1'b1;
                    state_next = status.bypass ? S_FINISH : S_DELTA;
                end
            end
            S_DELTA:
            begin
                cmd.delta  = 1'b1;
                state_next = S_ABS;
            end
            S_ABS:
            begin
                cmd.absval = 1'b1;
                cnt_next   = dtc_pkg::CNT_W'(dtc_pkg::MUL_STEPS - 1);
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    cnt_next   = dtc_pkg::CNT_W'(dtc_pkg::DIV_STEPS - 1);
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    state_next = S_SIGN;
                end
            end
            S_SIGN:
            begin
                cmd.sign   = 1'b1;
                state_next = S_ADDV;
            end
            S_ADDV:
            begin
                cmd.add_ev = 1'b1;
                state_next = S_ADDS;
            end
            S_ADDS:
            begin
                cmd.add_start = 1'b1;
                state_next    = S_FINISH;
            end
            S_FINISH:
            begin
                // hold the result until the output register frees up
                if (out_free)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/dtc_datapath.sv -----
module dtc_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [dtc_pkg::INDEX_W-1:0]        cfg_index,
    input  logic [dtc_pkg::TIME_W-1:0]         cfg_data,
    input  logic [dtc_pkg::TIME_W-1:0]         physical_ns,
    input  dtc_pkg::cmd_t                      cmd,
    output dtc_pkg::status_t                   status,
    output logic [dtc_pkg::TIME_W-1:0]         virtual_ns
);

    localparam int PAD_W = dtc_pkg::ACC_W - dtc_pkg::WIDE_W;

    logic [dtc_pkg::FACTOR_W-1:0] factor_reg;
    logic [dtc_pkg::TIME_W-1:0]   start_reg;
    logic [dtc_pkg::TIME_W-1:0]   freeze_reg;
    logic [dtc_pkg::WIDE_W-1:0]   ep_reg, ep_next;
    logic [dtc_pkg::WIDE_W-1:0]   ev_reg, ev_next;

    logic [dtc_pkg::WIDE_W-1:0]   running_reg;
    logic [dtc_pkg::WIDE_W:0]     delta_reg;
    logic                         neg_reg;
    logic [dtc_pkg::PROD_W-1:0]   mcand_reg;
    logic [dtc_pkg::PROD_W-1:0]   prod_reg;
    logic [dtc_pkg::FACTOR_W-1:0] mplier_reg;
    logic [dtc_pkg::FACTOR_W-1:0] divisor_reg;
    logic [dtc_pkg::REM_W-1:0]    rem_reg;
    logic [dtc_pkg::ACC_W-1:0]    acc_reg;
    logic [dtc_pkg::TIME_W-1:0]   res_reg;
    logic [dtc_pkg::TIME_W-1:0]   out_reg;

    logic [dtc_pkg::TIME_W-1:0]   base;
    logic [dtc_pkg::WIDE_W:0]     delta_mag;
    logic                         fneg;
    logic [dtc_pkg::FACTOR_W-1:0] fmag;
    logic [dtc_pkg::FACTOR_W-1:0] mul_val;
    logic [dtc_pkg::FACTOR_W-1:0] div_val;
    logic [dtc_pkg::REM_W:0]      trial;
    logic                         qbit;
    logic [dtc_pkg::ACC_W-1:0]    quot_ext;
    logic [dtc_pkg::ACC_W-1:0]    total;
    logic [dtc_pkg::TIME_W-1:0]   total_sat;
    logic [dtc_pkg::WIDE_W-1:0]   acc_sat;
    logic                         acc_fits;
    logic                         total_high;

    assign status.bypass = (start_reg == '0);
    assign virtual_ns    = out_reg;

    assign base      = (freeze_reg == '0) ? physical_ns : freeze_reg;
    assign delta_mag = delta_reg[dtc_pkg::WIDE_W] ? -delta_reg : delta_reg;

    // factor decode: zero means unscaled, so multiply and divide by one
    assign fneg = factor_reg[dtc_pkg::FACTOR_W-1];
    assign fmag = fneg ? -factor_reg : factor_reg;
    always_comb
    begin
        if (fmag == '0)
        begin
            mul_val = dtc_pkg::FACTOR_W'(1);
            div_val = dtc_pkg::FACTOR_W'(1);
        end
        else if (fneg)
        begin
            mul_val = fmag;
            div_val = dtc_pkg::SCALE_UNIT;
        end
        else
        begin
            mul_val = dtc_pkg::SCALE_UNIT;
            div_val = fmag;
        end
    end

    // one restoring division step; the quotient shifts into the product register
    assign trial = {rem_reg, prod_reg[dtc_pkg::PROD_W-1]};
    assign qbit  = (trial >= {1'b0, divisor_reg});

    assign quot_ext = {{(dtc_pkg::ACC_W - dtc_pkg::PROD_W){1'b0}}, prod_reg};
    assign total    = acc_reg + {{(dtc_pkg::ACC_W - dtc_pkg::TIME_W){1'b0}}, start_reg};

    // saturate the dilated total to signed 64 bits for storage
    assign acc_fits = (acc_reg[dtc_pkg::ACC_W-1:dtc_pkg::WIDE_W-1] == '0)
                   || (acc_reg[dtc_pkg::ACC_W-1:dtc_pkg::WIDE_W-1] == '1);
    always_comb
    begin
        if (acc_fits)
        begin
            acc_sat = acc_reg[dtc_pkg::WIDE_W-1:0];
        end
        else if (acc_reg[dtc_pkg::ACC_W-1])
        begin
            acc_sat = {1'b1, {(dtc_pkg::WIDE_W-1){1'b0}}};
        end
        else
        begin
            acc_sat = {1'b0, {(dtc_pkg::WIDE_W-1){1'b1}}};
        end
    end

    assign total_high = (total[dtc_pkg::ACC_W-1:dtc_pkg::TIME_W] != '0);
    always_comb
    begin
        priority if (total[dtc_pkg::ACC_W-1])
        begin
            total_sat = '0;
        end
        else if (total_high)
        begin
            total_sat = '1;
        end
        else
        begin
            total_sat = total[dtc_pkg::TIME_W-1:0];
        end
    end

    always_comb
    begin
        ep_next = ep_reg;
        ev_next = ev_reg;
        if (cmd.add_start && (freeze_reg == '0))
        begin
            ep_next = running_reg;
            ev_next = acc_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            factor_reg <= '0;
            start_reg  <= '0;
            freeze_reg <= '0;
            ep_reg     <= '0;
            ev_reg     <= '0;
        end
        else
        begin
            ep_reg <= ep_next;
            ev_reg <= ev_next;
            if (cfg_wr_en)
            begin
                unique case (cfg_index)
                    dtc_pkg::REG_FACTOR: factor_reg <= cfg_data[dtc_pkg::FACTOR_W-1:0];
                    dtc_pkg::REG_START:  start_reg  <= cfg_data;
                    dtc_pkg::REG_FREEZE: freeze_reg <= cfg_data;
                    default:             ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            running_reg <= {1'b0, base} - {1'b0, start_reg};
            res_reg     <= physical_ns;
        end
        if (cmd.delta)
        begin
            delta_reg <= {running_reg[dtc_pkg::WIDE_W-1], running_reg}
                       - {ep_reg[dtc_pkg::WIDE_W-1], ep_reg};
        end
        if (cmd.absval)
        begin
            neg_reg     <= delta_reg[dtc_pkg::WIDE_W];
            mcand_reg   <= {{(dtc_pkg::PROD_W - dtc_pkg::WIDE_W){1'b0}},
                            delta_mag[dtc_pkg::WIDE_W-1:0]};
            prod_reg    <= '0;
            rem_reg     <= '0;
            mplier_reg  <= mul_val;
            divisor_reg <= div_val;
        end
        if (cmd.mul_step)
        begin
            if (mplier_reg[0])
            begin
                prod_reg <= prod_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[dtc_pkg::PROD_W-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[dtc_pkg::FACTOR_W-1:1]};
        end
        if (cmd.div_step)
        begin
            rem_reg  <= qbit ? dtc_pkg::REM_W'(trial - {1'b0, divisor_reg})
                             : trial[dtc_pkg::REM_W-1:0];
            prod_reg <= {prod_reg[dtc_pkg::PROD_W-2:0], qbit};
        end
        if (cmd.sign)
        begin
            acc_reg <= neg_reg ? -quot_ext : quot_ext;
        end
        if (cmd.add_ev)
        begin
            acc_reg <= acc_reg + {{PAD_W{ev_reg[dtc_pkg::WIDE_W-1]}}, ev_reg};
        end
        if (cmd.add_start)
        begin
            res_reg <= total_sat;
        end
        if (cmd.out_load)
        begin
            out_reg <= res_reg;
        end
    end

endmodule

// ----- rtl/dilated_time_clock.sv -----
// Dilated time clock: maps a physical time word (ns) to a dilated virtual time. With
// start_time zero the word passes through unchanged, via res_reg into the output register.
// Otherwise each word goes through setup, a bit-serial multiply of 21 steps by 1000 or the
// factor magnitude (one for a zero factor), a radix-2 restoring divide of 85 steps, then the
// sign and accumulate steps. The output register frees the input side, so the next word is
// taken while a result still waits. Write configuration only while idle.
module dilated_time_clock (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_wr_en,
    input  logic [dtc_pkg::INDEX_W-1:0] cfg_index,
    input  logic [dtc_pkg::TIME_W-1:0]  cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [dtc_pkg::TIME_W-1:0]  physical_ns,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [dtc_pkg::TIME_W-1:0]  virtual_ns
);

    dtc_pkg::cmd_t    cmd;
    dtc_pkg::status_t status;

    dtc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    dtc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .physical_ns (physical_ns),
        .cmd         (cmd),
        .status      (status),
        .virtual_ns  (virtual_ns)
    );

endmodule
